### rtl/core/hav_pkg.sv
// Shared constants, types and the arctangent table for the haversine distance core.
`timescale 1ns / 1ps
`default_nettype none

package hav_pkg;

    localparam int ITER     = 32;
    localparam int ANG_W    = 40;
    localparam int XY_W     = 34;
    localparam int Z_W      = 41;
    localparam int PROD_W   = 64;
    localparam int TERM_W   = 61;
    localparam int ROOT_W   = 31;
    localparam int THETA_W  = 39;
    localparam int RPI_W    = 31;
    localparam int DIST_W   = 25;
    localparam int ROT_LAT  = ITER + 1;
    localparam int SQRT_LAT = ROOT_W;

    localparam logic signed [XY_W-1:0] GAIN_INV = 34'sd652032874;

    localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
    localparam logic [63:0] PI_Q32   = (PI_Q60 + 64'd134217728) >> 28;
    localparam logic [63:0] EARTH_R  = 64'd6371010;
    localparam logic [63:0] RPI_FULL = (EARTH_R * PI_Q32 + 64'd33554432) >> 26;
    localparam logic [RPI_W-1:0] RPI = RPI_FULL[RPI_W-1:0];

    localparam logic [TERM_W-1:0]  ONE_Q60   = {1'b1, 60'd0};
    localparam logic [THETA_W-1:0] THETA_MAX = {1'b1, 38'd0};
    localparam logic [DIST_W-1:0]  DIST_MAX  = 25'd20015119;

    typedef enum logic [1:0] {
        Q_FIRST,
        Q_SECOND,
        Q_THIRD,
        Q_FOURTH
    } t_quad;

    typedef logic signed [Z_W-1:0] t_atan_rom [ITER];

    // Bit-by-bit restoring division, used only while the table is elaborated.
    function automatic logic [63:0] udiv_c(logic [63:0] num, logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            quo = quo << 1;
            if (rem >= den) begin
                rem    = rem - den;
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Entry i is atan(2^-i) in angle units of 2^40 per turn, rounded to nearest.
    // The arctangent comes from its power series in Q60 with truncated terms.
    function automatic t_atan_rom build_atan();
        t_atan_rom   rom;
        logic [63:0] pw;
        logic [63:0] sum;
        logic [63:0] rem;
        logic [63:0] q;
        rom[0] = signed'(Z_W'(64'd1 << 37));
        for (int i = 1; i < ITER; i++) begin
            pw  = 64'd1 << (60 - i);
            sum = '0;
            for (int k = 0; k < 64; k++) begin
                if (pw != 64'd0) begin
                    if (k[0]) begin
                        sum = sum - udiv_c(pw, 64'(2 * k + 1));
                    end else begin
                        sum = sum + udiv_c(pw, 64'(2 * k + 1));
                    end
                    pw = pw >> (2 * i);
                end
            end
            rem = sum;
            q   = '0;
            for (int b = 0; b < 39; b++) begin
                rem = rem << 1;
                q   = q << 1;
                if (rem >= PI_Q60) begin
                    rem  = rem - PI_Q60;
                    q[0] = 1'b1;
                end
            end
            if ((rem << 1) >= PI_Q60) begin
                q = q + 64'd1;
            end
            rom[i] = signed'(Z_W'(q));
        end
        return rom;
    endfunction

    localparam t_atan_rom ATAN = build_atan();

endpackage

`default_nettype wire

### rtl/core/haversine_distance_core.sv
// Top level of the haversine great-circle distance core.
// Usage:
// The input channel takes one word per accepted cycle: two points, each a longitude
// and latitude in signed 32-bit binary angle units where 2^31 stands for pi. A word is
// accepted at a rising edge with i_valid high and o_stall low.
// The output channel gives one word per input word, o_dist_m in whole meters, taken at
// an edge with o_valid high and i_stall low. Words leave in the order they came in.
// Throughput is one word per cycle unless the receiver stalls, as the datapath is fully
// pipelined: every CORDIC iteration and every square root bit has a register stage.
// When the receiver stalls while a result is shown, the whole pipeline holds and
// o_stall rises, so nothing is lost or repeated; a stall with no result shown is ignored.
// The synchronous active-low reset clears the valid bits only, so after reset the
// pipeline is empty and the block accepts a word in the very next cycle.
`timescale 1ns / 1ps
`default_nettype none

module haversine_distance_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [31:0]            i_lon_a,
    input  wire logic signed [31:0]            i_lat_a,
    input  wire logic signed [31:0]            i_lon_b,
    input  wire logic signed [31:0]            i_lat_b,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [hav_pkg::DIST_W-1:0]         o_dist_m
);

    // Stage count: input register, rotation, five product stages, square root,
    // vectoring, then clamp, multiply and round.
    localparam int LAT     = 1 + hav_pkg::ROT_LAT + 5 + hav_pkg::SQRT_LAT + hav_pkg::ITER + 3;
    localparam int SUM_W   = hav_pkg::PROD_W + 1;
    localparam int MH_W    = hav_pkg::THETA_W - 20 + hav_pkg::RPI_W;
    localparam int ML_W    = 20 + hav_pkg::RPI_W;
    localparam int ACC_W   = ML_W;
    localparam logic signed [SUM_W-1:0] ONE_S = signed'(SUM_W'(hav_pkg::ONE_Q60));
    localparam logic signed [hav_pkg::Z_W-1:0] THETA_MAX_S =
        signed'(hav_pkg::Z_W'(hav_pkg::THETA_MAX));

    // Round a Q60 product to Q30 with ties going up.
    function automatic logic signed [hav_pkg::XY_W-1:0] rnd30(
        logic signed [hav_pkg::PROD_W-1:0] v
    );
        logic signed [hav_pkg::PROD_W-1:0] t;
        t = (v + (hav_pkg::PROD_W'(1) << 29)) >>> 30;
        return signed'(t[hav_pkg::XY_W-1:0]);
    endfunction

    logic            w_en;
    logic [LAT-1:0]  r_vld;

    // The pipeline moves as one; it halts only while a shown result is stalled.
    assign o_stall = r_vld[LAT-1] & i_stall;
    assign w_en    = !o_stall;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Input stage: the differences wrap modulo one turn and are halved exactly on
    // the 40-bit angle; latitudes go straight to the cosine units.
    logic [hav_pkg::ANG_W-1:0] r_hlat;
    logic [hav_pkg::ANG_W-1:0] r_hlon;
    logic [hav_pkg::ANG_W-1:0] r_ala;
    logic [hav_pkg::ANG_W-1:0] r_alb;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hlat <= {1'b0, i_lat_b - i_lat_a, 7'd0};
            r_hlon <= {1'b0, i_lon_b - i_lon_a, 7'd0};
            r_ala  <= {i_lat_a, 8'd0};
            r_alb  <= {i_lat_b, 8'd0};
        end
    end

    logic signed [hav_pkg::XY_W-1:0] w_slat;
    logic signed [hav_pkg::XY_W-1:0] w_slon;
    logic signed [hav_pkg::XY_W-1:0] w_ca;
    logic signed [hav_pkg::XY_W-1:0] w_cb;

    hav_rot u_rot_lat (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ang (r_hlat),
        .o_sin (w_slat),
        .o_cos ()
    );

    hav_rot u_rot_lon (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ang (r_hlon),
        .o_sin (w_slon),
        .o_cos ()
    );

    hav_rot u_rot_ca (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ang (r_ala),
        .o_sin (),
        .o_cos (w_ca)
    );

    hav_rot u_rot_cb (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ang (r_alb),
        .o_sin (),
        .o_cos (w_cb)
    );

    // Haversine term. The latitude square stays exact in Q60, while the cosine
    // product and the longitude square are each rounded to Q30 before they meet.
    logic signed [hav_pkg::PROD_W-1:0] r_p_lat;
    logic signed [hav_pkg::PROD_W-1:0] r_p_cc;
    logic signed [hav_pkg::PROD_W-1:0] r_p_lon;
    logic signed [hav_pkg::PROD_W-1:0] r_sq_lat2;
    logic signed [hav_pkg::XY_W-1:0]   r_r_cc;
    logic signed [hav_pkg::XY_W-1:0]   r_r_lon;
    logic signed [hav_pkg::PROD_W-1:0] r_sq_lat3;
    logic signed [hav_pkg::PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]           w_sum;
    logic [hav_pkg::TERM_W-1:0]        n_term;
    logic [hav_pkg::TERM_W-1:0]        r_term4;
    logic [hav_pkg::TERM_W-1:0]        r_term5;
    logic [hav_pkg::TERM_W-1:0]        r_cterm5;

    assign w_sum = SUM_W'(r_sq_lat3) + SUM_W'(r_prod);

    // Rounding may push the term just outside 0..1, so it is clamped.
    always_comb begin
        priority if (w_sum[SUM_W-1]) begin
            n_term = '0;
        end else if (w_sum > ONE_S) begin
            n_term = hav_pkg::ONE_Q60;
        end else begin
            n_term = w_sum[hav_pkg::TERM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_lat   <= hav_pkg::PROD_W'(w_slat * w_slat);
            r_p_cc    <= hav_pkg::PROD_W'(w_ca * w_cb);
            r_p_lon   <= hav_pkg::PROD_W'(w_slon * w_slon);
            r_sq_lat2 <= r_p_lat;
            r_r_cc    <= rnd30(r_p_cc);
            r_r_lon   <= rnd30(r_p_lon);
            r_sq_lat3 <= r_sq_lat2;
            r_prod    <= hav_pkg::PROD_W'(r_r_cc * r_r_lon);
            r_term4   <= n_term;
            r_term5   <= r_term4;
            r_cterm5  <= hav_pkg::ONE_Q60 - r_term4;
        end
    end

    // asin(sqrt(h)) is the angle of the vector (sqrt(1-h), sqrt(h)).
    logic [hav_pkg::ROOT_W-1:0] w_ys;
    logic [hav_pkg::ROOT_W-1:0] w_xs;

    hav_sqrt u_sqrt_y (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  (r_term5),
        .o_root (w_ys)
    );

    hav_sqrt u_sqrt_x (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  (r_cterm5),
        .o_root (w_xs)
    );

    // Vectoring CORDIC drives y to zero and collects the angle in z.
    logic signed [hav_pkg::XY_W-1:0] r_vx [hav_pkg::ITER];
    logic signed [hav_pkg::XY_W-1:0] r_vy [hav_pkg::ITER];
    logic signed [hav_pkg::Z_W-1:0]  r_vz [hav_pkg::ITER];

    generate
        for (genvar g = 0; g < hav_pkg::ITER; g++) begin : g_vec
            logic signed [hav_pkg::XY_W-1:0] x_in;
            logic signed [hav_pkg::XY_W-1:0] y_in;
            logic signed [hav_pkg::Z_W-1:0]  z_in;

            if (g == 0) begin : g_first
                assign x_in = signed'(hav_pkg::XY_W'(w_xs));
                assign y_in = signed'(hav_pkg::XY_W'(w_ys));
                assign z_in = '0;
            end else begin : g_next
                assign x_in = r_vx[g-1];
                assign y_in = r_vy[g-1];
                assign z_in = r_vz[g-1];
            end

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    if (!y_in[hav_pkg::XY_W-1]) begin
                        r_vx[g] <= x_in + (y_in >>> g);
                        r_vy[g] <= y_in - (x_in >>> g);
                        r_vz[g] <= z_in + hav_pkg::ATAN[g];
                    end else begin
                        r_vx[g] <= x_in - (y_in >>> g);
                        r_vy[g] <= y_in + (x_in >>> g);
                        r_vz[g] <= z_in - hav_pkg::ATAN[g];
                    end
                end
            end
        end
    endgenerate

    // Scale to meters: the angle is split at bit 20 so each product stays narrow.
    logic signed [hav_pkg::Z_W-1:0]  w_theta;
    logic [hav_pkg::THETA_W-1:0]     n_theta;
    logic [hav_pkg::THETA_W-1:0]     r_theta;
    logic [MH_W-1:0]                 r_mh;
    logic [ML_W-1:0]                 r_ml;
    logic [ACC_W-1:0]                w_acc;
    logic [ACC_W-1:0]                w_rnd;
    logic [hav_pkg::DIST_W-1:0]      r_dist;

    assign w_theta = r_vz[hav_pkg::ITER-1];

    always_comb begin
        priority if (w_theta[hav_pkg::Z_W-1]) begin
            n_theta = '0;
        end else if (w_theta > THETA_MAX_S) begin
            n_theta = hav_pkg::THETA_MAX;
        end else begin
            n_theta = w_theta[hav_pkg::THETA_W-1:0];
        end
    end

    assign w_acc = ACC_W'(r_mh) + ACC_W'(r_ml >> 20);
    assign w_rnd = w_acc + (ACC_W'(1) << 23);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_theta <= n_theta;
            r_mh    <= MH_W'(r_theta[hav_pkg::THETA_W-1:20]) * MH_W'(hav_pkg::RPI);
            r_ml    <= ML_W'(r_theta[19:0]) * ML_W'(hav_pkg::RPI);
            r_dist  <= w_rnd[hav_pkg::DIST_W+23:24];
        end
    end

    assign o_dist_m = r_dist;

`ifndef SYNTHESIS
    // A great-circle distance never exceeds half the circumference.
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_dist_m <= hav_pkg::DIST_MAX))
        else $error("distance beyond half circumference");

    // A word in the last stage but one reaches the output stage whenever the pipeline moves.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_vld[LAT-2]) |=> o_valid)
        else $error("word lost at the output stage");

    // While the pipeline is held, no valid bit may move.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("valid bits moved during a stall");
`endif

endmodule

`default_nettype wire

### rtl/core/hav_rot.sv
// Pipelined rotation CORDIC giving the sine and cosine of a 40-bit binary angle.
`timescale 1ns / 1ps
`default_nettype none

module hav_rot (
    input  wire logic                             i_clk,
    input  wire logic                             i_en,
    input  wire logic [hav_pkg::ANG_W-1:0]        i_ang,
    output logic signed [hav_pkg::XY_W-1:0]       o_sin,
    output logic signed [hav_pkg::XY_W-1:0]       o_cos
);

    logic signed [hav_pkg::XY_W-1:0] r_x [hav_pkg::ITER];
    logic signed [hav_pkg::XY_W-1:0] r_y [hav_pkg::ITER];
    logic signed [hav_pkg::Z_W-1:0]  r_z [hav_pkg::ITER];
    hav_pkg::t_quad                  r_q [hav_pkg::ITER];

    generate
        for (genvar g = 0; g < hav_pkg::ITER; g++) begin : g_stage
            logic signed [hav_pkg::XY_W-1:0] x_in;
            logic signed [hav_pkg::XY_W-1:0] y_in;
            logic signed [hav_pkg::Z_W-1:0]  z_in;
            hav_pkg::t_quad                  q_in;

            if (g == 0) begin : g_first
                // The residual inside the quadrant is rotated; the quadrant is applied at the end.
                assign x_in = hav_pkg::GAIN_INV;
                assign y_in = '0;
                assign z_in = signed'({3'b000, i_ang[hav_pkg::ANG_W-3:0]});
                assign q_in = hav_pkg::t_quad'(i_ang[hav_pkg::ANG_W-1:hav_pkg::ANG_W-2]);
            end else begin : g_next
                assign x_in = r_x[g-1];
                assign y_in = r_y[g-1];
                assign z_in = r_z[g-1];
                assign q_in = r_q[g-1];
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (!z_in[hav_pkg::Z_W-1]) begin
                        r_x[g] <= x_in - (y_in >>> g);
                        r_y[g] <= y_in + (x_in >>> g);
                        r_z[g] <= z_in - hav_pkg::ATAN[g];
                    end else begin
                        r_x[g] <= x_in + (y_in >>> g);
                        r_y[g] <= y_in - (x_in >>> g);
                        r_z[g] <= z_in + hav_pkg::ATAN[g];
                    end
                    r_q[g] <= q_in;
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            unique case (r_q[hav_pkg::ITER-1])
                hav_pkg::Q_FIRST: begin
                    o_sin <= r_y[hav_pkg::ITER-1];
                    o_cos <= r_x[hav_pkg::ITER-1];
                end
                hav_pkg::Q_SECOND: begin
                    o_sin <= r_x[hav_pkg::ITER-1];
                    o_cos <= -r_y[hav_pkg::ITER-1];
                end
                hav_pkg::Q_THIRD: begin
                    o_sin <= -r_y[hav_pkg::ITER-1];
                    o_cos <= -r_x[hav_pkg::ITER-1];
                end
                default: begin
                    o_sin <= -r_x[hav_pkg::ITER-1];
                    o_cos <= r_y[hav_pkg::ITER-1];
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/core/hav_sqrt.sv
// Pipelined floor square root, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module hav_sqrt (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire logic [hav_pkg::TERM_W-1:0]     i_val,
    output logic [hav_pkg::ROOT_W-1:0]          o_root
);

    localparam int TRIAL_W = 2 * hav_pkg::ROOT_W + 1;

    logic [hav_pkg::TERM_W-1:0] r_rem  [hav_pkg::ROOT_W];
    logic [hav_pkg::ROOT_W-1:0] r_root [hav_pkg::ROOT_W];

    generate
        for (genvar g = 0; g < hav_pkg::ROOT_W; g++) begin : g_stage
            localparam int B = hav_pkg::ROOT_W - 1 - g;
            logic [hav_pkg::TERM_W-1:0] rem_in;
            logic [hav_pkg::ROOT_W-1:0] root_in;
            logic [TRIAL_W-1:0]         trial;

            if (g == 0) begin : g_first
                assign rem_in  = i_val;
                assign root_in = '0;
            end else begin : g_next
                assign rem_in  = r_rem[g-1];
                assign root_in = r_root[g-1];
            end

            // Setting bit B grows the square by 2^(B+1)*root + 2^(2B).
            assign trial = (TRIAL_W'(root_in) << (B + 1)) | (TRIAL_W'(1) << (2 * B));

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (TRIAL_W'(rem_in) >= trial) begin
                        r_rem[g]  <= rem_in - trial[hav_pkg::TERM_W-1:0];
                        r_root[g] <= root_in | (hav_pkg::ROOT_W'(1) << B);
                    end else begin
                        r_rem[g]  <= rem_in;
                        r_root[g] <= root_in;
                    end
                end
            end
        end
    endgenerate

    assign o_root = r_root[hav_pkg::ROOT_W-1];

endmodule

`default_nettype wire

### bench/tb_haversine_distance_core.sv
// Self-checking testbench for the haversine distance core, with its own bit-exact predictor.
`timescale 1ns / 1ps

module tb_haversine_distance_core;

    localparam int          STEPS        = 32;
    localparam int          RESET_CYCLES = 7;
    localparam int          DRAIN_CYCLES = 140;
    localparam longint      CYCLE_LIMIT  = 400000;
    localparam int          MAX_SHOWN    = 10;
    localparam longint      CORDIC_START = 652032874;
    localparam longint unsigned PI_Q60   = 64'h3243F6A8885A308D;
    localparam longint unsigned RADIUS_M = 6371010;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    logic signed [31:0]            i_lon_a;
    logic signed [31:0]            i_lat_a;
    logic signed [31:0]            i_lon_b;
    logic signed [31:0]            i_lat_b;
    logic                          o_valid;
    logic                          i_stall;
    logic [hav_pkg::DIST_W-1:0]    o_dist_m;

    haversine_distance_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_lon_a  (i_lon_a),
        .i_lat_a  (i_lat_a),
        .i_lon_b  (i_lon_b),
        .i_lat_b  (i_lat_b),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_dist_m (o_dist_m)
    );

    // Arctangent table in angle units of 2^40 per turn, and the scale R*pi.
    longint            atan_tab [STEPS];
    longint unsigned   r_pi;

    logic [hav_pkg::DIST_W-1:0] pending_dist [$];
    int     mismatches;
    longint cycle_count;
    int     burst_left;
    int     stall_mode;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // The table entries follow the arctangent power series in Q60, divided by pi.
    initial begin
        longint unsigned pw, acc, rem, quo, pi_q32;
        int k;
        atan_tab[0] = 64'd1 << 37;
        for (int i = 1; i < STEPS; i++) begin
            pw  = 64'd1 << (60 - i);
            acc = 0;
            k   = 0;
            while (pw != 0) begin
                if (k % 2 == 1) acc = acc - pw / (2 * k + 1);
                else acc = acc + pw / (2 * k + 1);
                pw = pw >> (2 * i);
                k++;
            end
            rem = acc;
            quo = 0;
            for (int b = 0; b < 39; b++) begin
                rem = rem << 1;
                quo = quo << 1;
                if (rem >= PI_Q60) begin
                    rem = rem - PI_Q60;
                    quo = quo | 1;
                end
            end
            if (2 * rem >= PI_Q60) quo = quo + 1;
            atan_tab[i] = longint'(quo);
        end
        pi_q32 = (PI_Q60 + (64'd1 << 27)) >> 28;
        r_pi   = (RADIUS_M * pi_q32 + (64'd1 << 25)) >> 26;
    end

    // Rotation CORDIC on the residual within a quadrant; the quadrant is applied last.
    task automatic sine_cosine(input longint unsigned ang, output longint s, output longint c);
        longint x, y, z, dx, dy;
        logic [1:0] quad;
        quad = ang[39:38];
        z    = longint'(ang & ((64'd1 << 38) - 1));
        x    = CORDIC_START;
        y    = 0;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - atan_tab[i];
            end else begin
                x = x + dx; y = y - dy; z = z + atan_tab[i];
            end
        end
        case (quad)
            hav_pkg::Q_FIRST:  begin s = y;  c = x;  end
            hav_pkg::Q_SECOND: begin s = x;  c = -y; end
            hav_pkg::Q_THIRD:  begin s = -y; c = -x; end
            default:           begin s = -x; c = y;  end
        endcase
    endtask

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint round_q30(longint v);
        return (v + (64'sd1 << 29)) >>> 30;
    endfunction

    task automatic predict_distance(input logic [31:0] lon_a, input logic [31:0] lat_a,
                                    input logic [31:0] lon_b, input logic [31:0] lat_b,
                                    output logic [hav_pkg::DIST_W-1:0] want_m);
        logic [31:0]     dlat, dlon;
        longint          s_lat, s_lon, c_a, c_b, spare, term, x, y, z, dx, dy;
        longint unsigned th, tl, acc;
        dlat = lat_b - lat_a;
        dlon = lon_b - lon_a;
        sine_cosine({25'd0, dlat, 7'd0}, s_lat, spare);
        sine_cosine({25'd0, dlon, 7'd0}, s_lon, spare);
        sine_cosine({24'd0, lat_a, 8'd0}, spare, c_a);
        sine_cosine({24'd0, lat_b, 8'd0}, spare, c_b);
        term = s_lat * s_lat + round_q30(c_a * c_b) * round_q30(s_lon * s_lon);
        // Rounding may leave the term just outside 0..1.
        if (term < 0) term = 0;
        if (term > (64'sd1 << 60)) term = 64'sd1 << 60;
        y = longint'(floor_root(term));
        x = longint'(floor_root((64'sd1 << 60) - term));
        z = 0;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx; y = y - dy; z = z + atan_tab[i];
            end else begin
                x = x - dx; y = y + dy; z = z - atan_tab[i];
            end
        end
        if (z < 0) z = 0;
        if (z > (64'sd1 << 38)) z = 64'sd1 << 38;
        th     = longint'(z) >> 20;
        tl     = longint'(z) & ((64'd1 << 20) - 1);
        acc    = th * r_pi + ((tl * r_pi) >> 20);
        want_m = hav_pkg::DIST_W'((acc + (64'd1 << 23)) >> 24);
    endtask

    // Sends one word in bursts; the expectation is queued at the accepting edge.
    task automatic send_points(input logic [31:0] lon_a, input logic [31:0] lat_a,
                               input logic [31:0] lon_b, input logic [31:0] lat_b);
        logic [hav_pkg::DIST_W-1:0] want_m;
        int gap;
        predict_distance(lon_a, lat_a, lon_b, lat_b, want_m);
        i_lon_a <= lon_a;
        i_lat_a <= lat_a;
        i_lon_b <= lon_b;
        i_lat_b <= lat_b;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_dist.push_back(want_m);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap        = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // Receiver stalls follow a mode that is redrawn at random as the run goes on.
    always @(negedge i_clk) begin
        if (cycle_count % 300 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 9) < 3);
            2:       i_stall <= (cycle_count % 7) < 2;
            default: i_stall <= ($urandom_range(0, 9) < 8);
        endcase
    end

    always @(posedge i_clk) begin
        logic [hav_pkg::DIST_W-1:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_dist.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("Unexpected word: dist_m=%0d", o_dist_m);
            end else begin
                want = pending_dist.pop_front();
                if (o_dist_m !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("dist_m mismatch: expected %0d, got %0d", want, o_dist_m);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Same point, antipodes, field extremes and latitudes past the poles.
    task automatic test_directed();
        send_points(32'd0, 32'd0, 32'd0, 32'd0);
        send_points(32'h12345678, 32'h0ABCDEF0, 32'h12345678, 32'h0ABCDEF0);
        send_points(32'd0, 32'd0, 32'h80000000, 32'd0);
        send_points(32'h20000000, 32'h10000000, 32'hA0000000, 32'hF0000000);
        send_points(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_points(32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0, 32'd0);
        send_points(32'd0, 32'h40000000, 32'd0, 32'hC0000000);
        send_points(32'd0, 32'h40000000, 32'h55555555, 32'h40000000);
        send_points(32'h10000000, 32'h60000000, 32'h90000000, 32'h30000000);
        send_points(32'h00000000, 32'h70000000, 32'h40000000, 32'hB0000000);
        send_points(32'd0, 32'd0, 32'd1, 32'd0);
        send_points(32'd0, 32'd0, 32'd0, 32'd1);
        send_points(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF);
        send_points(32'hFFFFFFFF, 32'h00000000, 32'h00000000, 32'hFFFFFFFF);
        send_points(32'h40000000, 32'h20000000, 32'hC0000000, 32'hE0000000);
    endtask

    task automatic test_random_points();
        for (int n = 0; n < 300; n++)
            send_points($urandom, $urandom, $urandom, $urandom);
    endtask

    // Nearby pairs exercise the small-term end of the square root and arcsine.
    task automatic test_near_points();
        logic [31:0] lon, lat;
        for (int n = 0; n < 250; n++) begin
            lon = $urandom;
            lat = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h7FFFFFF);
            send_points(lon, lat, lon + ($urandom >> $urandom_range(8, 31)),
                        lat - ($urandom >> $urandom_range(8, 31)));
        end
    endtask

    // Pairs near the antipode push the term against its upper clamp.
    task automatic test_far_points();
        logic [31:0] lon, lat;
        for (int n = 0; n < 150; n++) begin
            lon = $urandom;
            lat = $urandom;
            send_points(lon, lat, lon + 32'h80000000 + ($urandom >> $urandom_range(16, 31)),
                        -lat + ($urandom >> $urandom_range(16, 31)));
        end
    endtask

    initial begin
        int waited;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_stall     <= 1'b0;
        i_lon_a     <= '0;
        i_lat_a     <= '0;
        i_lon_b     <= '0;
        i_lat_b     <= '0;
        mismatches  = 0;
        cycle_count = 0;
        burst_left  = 0;
        stall_mode  = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_points();
        test_near_points();
        test_far_points();
        i_valid <= 1'b0;
        waited = 0;
        while (pending_dist.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_dist.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### haversine_distance_core.f
rtl/core/hav_pkg.sv
rtl/core/hav_rot.sv
rtl/core/hav_sqrt.sv
rtl/core/haversine_distance_core.sv
bench/tb_haversine_distance_core.sv
